// File: hw/rtl/spq_pkg.sv
// spq_pkg: shared constants, codes and types for the sorted priority queue
// no dependencies; used by spq_cell and sorted_priority_queue

package spq_pkg;

	localparam int CAPACITY   = 64;
	localparam int DATA_WIDTH = 32;

	// count holds 0..CAPACITY
	localparam int CNT_W = $clog2(CAPACITY + 1);

	// interface field widths
	localparam int VALUE_W  = 32;
	localparam int STATUS_W = 2;
	localparam int ECOUNT_W = 7;

	// request codes
	localparam logic REQ_ENQ = 1'b0;
	localparam logic REQ_DEQ = 1'b1;

	// status codes
	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

	typedef logic signed [DATA_WIDTH-1:0] data_t;

	// broadcast from the top level to every cell
	typedef struct packed {
		logic  enq;
		logic  deq;
		data_t value;
	} cell_ctrl_t;

endpackage

// File: hw/rtl/spq_cell.sv
// spq_cell: one slot of the sorted chain, holds one entry
// depends on spq_pkg

module spq_cell (
	input  logic               clk,
	input  spq_pkg::cell_ctrl_t ctrl,
	input  logic               occupied,
	input  logic               left_ge,
	input  spq_pkg::data_t     left_entry,
	input  spq_pkg::data_t     right_entry,
	output spq_pkg::data_t     entry,
	output logic               ge
);

	spq_pkg::data_t entry_q;

	// stored entry is at least the incoming value, so it stays put
	assign ge    = occupied && !(entry_q < ctrl.value);
	assign entry = entry_q;

	always_ff @(posedge clk) begin
		if (ctrl.enq) begin
			if (!ge) begin
				entry_q <= left_ge ? ctrl.value : left_entry;
			end
		end else if (ctrl.deq) begin
			entry_q <= right_entry;
		end
	end

endmodule

// File: hw/rtl/sorted_priority_queue.sv
// sorted_priority_queue: top level, a chain of spq_cell slots plus count and result registers
// depends on spq_pkg and spq_cell

// Max-priority queue of up to spq_pkg::CAPACITY signed entries, kept sorted
// in descending order in a row of cells. A transaction is accepted at any
// clock edge with start high; busy is always low, so a new transaction may
// come every cycle. Every transaction, enqueue or dequeue, gives exactly one
// result in the cycle after it: done is high for that single cycle and the result
// fields are valid with it; the receiver cannot stall, so it must take the
// result in that cycle. The cell row makes this possible: every
// cell compares the broadcast value with its own entry and either keeps its
// entry, takes the new value, or takes its neighbor's entry in the same edge.
// Equal values leave in arrival order. A dequeue on an empty queue returns
// -1 with status empty; an enqueue on a full queue is dropped with status
// full. No clearing pass is needed after reset: only the entry count and the result strobe are reset.

module sorted_priority_queue (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic                                req_type,
	input  logic signed [spq_pkg::VALUE_W-1:0]  value,
	output logic                                done,
	output logic signed [spq_pkg::VALUE_W-1:0]  out_value,
	output logic        [spq_pkg::STATUS_W-1:0] status,
	output logic        [spq_pkg::ECOUNT_W-1:0] entry_count,
	output logic                                is_empty
);

	logic [spq_pkg::CNT_W-1:0] count_q;
	logic [spq_pkg::CNT_W-1:0] count_next;
	logic                      accept;
	logic                      is_full;
	logic                      none_stored;
	spq_pkg::cell_ctrl_t       ctrl;

	spq_pkg::data_t cell_entry [spq_pkg::CAPACITY];
	logic           cell_ge    [spq_pkg::CAPACITY];

	// result registers
	logic                                done_q;
	logic signed [spq_pkg::VALUE_W-1:0]  out_value_q;
	logic        [spq_pkg::STATUS_W-1:0] status_q;

	// the chain finishes any request at the edge that accepts it, never stall the sender
	assign busy   = 1'b0;
	assign accept = start && !busy;

	assign is_full     = (count_q == spq_pkg::CNT_W'(spq_pkg::CAPACITY));
	assign none_stored = (count_q == '0);

	// control broadcast to the cells; value is sign extended or cut to the entry width
	assign ctrl.enq   = accept && (req_type == spq_pkg::REQ_ENQ) && !is_full;
	assign ctrl.deq   = accept && (req_type == spq_pkg::REQ_DEQ) && !none_stored;
	assign ctrl.value = spq_pkg::DATA_WIDTH'(value);

	always_comb begin
		count_next = count_q;
		if (ctrl.enq) begin
			count_next = count_q + 1'b1;
		end else if (ctrl.deq) begin
			count_next = count_q - 1'b1;
		end
	end

	// row of cells: cell 0 is the head and holds the maximum
	for (genvar i = 0; i < spq_pkg::CAPACITY; i++) begin : g_cell
		logic           occ;
		logic           lge;
		spq_pkg::data_t lent;
		spq_pkg::data_t rent;

		assign occ = (spq_pkg::CNT_W'(i) < count_q);

		if (i == 0) begin : g_head
			// nothing to the left: a smaller head takes the new value
			assign lge  = 1'b0;
			assign lent = ctrl.value;
		end else begin : g_mid
			assign lge  = cell_ge[i-1];
			assign lent = cell_entry[i-1];
		end

		if (i == spq_pkg::CAPACITY - 1) begin : g_tail
			// the tail slot is unoccupied after any dequeue, its contents do not matter
			assign rent = cell_entry[i];
		end else begin : g_body
			assign rent = cell_entry[i+1];
		end

		spq_cell u_cell (
			.clk         (clk),
			.ctrl        (ctrl),
			.occupied    (occ),
			.left_ge     (lge),
			.left_entry  (lent),
			.right_entry (rent),
			.entry       (cell_entry[i]),
			.ge          (cell_ge[i])
		);
	end

	// count and result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			count_q <= count_next;
			done_q  <= accept;
		end
	end

	// result payload, head is read before the shift lands
	always_ff @(posedge clk) begin
		if (accept) begin
			if (req_type == spq_pkg::REQ_ENQ) begin
				out_value_q <= '0;
				status_q    <= is_full ? spq_pkg::ST_FULL : spq_pkg::ST_OK;
			end else if (none_stored) begin
				out_value_q <= -32'sd1;
				status_q    <= spq_pkg::ST_EMPTY;
			end else begin
				out_value_q <= spq_pkg::VALUE_W'(cell_entry[0]);
				status_q    <= spq_pkg::ST_OK;
			end
		end
	end

	assign done        = done_q;
	assign out_value   = out_value_q;
	assign status      = status_q;
	assign entry_count = spq_pkg::ECOUNT_W'(count_q);
	assign is_empty    = none_stored;

	// count never exceeds the number of cells
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= spq_pkg::CNT_W'(spq_pkg::CAPACITY))
		else $error("entry count above capacity");

	// every accepted transaction gives a result in the next cycle
	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> done)
		else $error("missing result strobe");

	// no result without a request
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		!accept |=> !done)
		else $error("result without a request");

	// an accepted enqueue grows the count by one
	a_enq_count: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.enq |=> count_q == $past(count_q) + 1'b1)
		else $error("enqueue did not grow the count");

	// an empty-queue dequeue reports an empty queue and minus one
	a_empty_result: assert property (@(posedge clk) disable iff (!arst_n)
		done && status == spq_pkg::ST_EMPTY |-> is_empty && out_value == -32'sd1)
		else $error("empty dequeue result inconsistent");

endmodule

// File: tb/sv/sorted_priority_queue_tb.sv
// sorted_priority_queue_tb: self-checking testbench for the sorted max-priority queue
// depends on spq_pkg and sorted_priority_queue; directed table first, then random phases
// every result is compared with its typed row expectation or with a behavioral sorted list kept inside the testbench

module sorted_priority_queue_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RANDOM_ITEMS = 1150;
	localparam int MAX_GAP      = 18;
	localparam int TAIL_CYCLES  = 4;
	// slowest run is about 1300 transactions, each followed by its largest idle gap
	localparam int CYCLE_LIMIT  = 200000;
	localparam int PRINT_LIMIT  = 40;
	localparam int NUM_ROWS     = 21;

	typedef struct packed {
		logic signed [spq_pkg::VALUE_W-1:0]  out_value;
		logic        [spq_pkg::STATUS_W-1:0] status;
		logic        [spq_pkg::ECOUNT_W-1:0] entry_count;
		logic                                is_empty;
	} spq_result_t;

	// one row of the directed table; reps repeats the same transaction
	typedef struct {
		logic           req;
		spq_pkg::data_t val;
		int             reps;
		bit             fixed;
		spq_result_t    res;
	} stim_row_t;

	logic                                clk;
	logic                                arst_n;
	logic                                start;
	logic                                busy;
	logic                                req_type;
	logic signed [spq_pkg::VALUE_W-1:0]  value;
	logic                                done;
	logic signed [spq_pkg::VALUE_W-1:0]  out_value;
	logic        [spq_pkg::STATUS_W-1:0] status;
	logic        [spq_pkg::ECOUNT_W-1:0] entry_count;
	logic                                is_empty;

	// typed expectation travels with the transaction it belongs to
	bit          row_fixed;
	spq_result_t row_expect;

	// behavioral copy of the queue contents, head is the maximum
	spq_pkg::data_t sorted_entries[$];
	// results still owed by the block, oldest first
	spq_result_t    owed_results[$];

	int mismatch_count;
	int result_count;
	int cycle_count;

	stim_row_t dir_rows [NUM_ROWS];

	sorted_priority_queue i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.req_type    (req_type),
		.value       (value),
		.done        (done),
		.out_value   (out_value),
		.status      (status),
		.entry_count (entry_count),
		.is_empty    (is_empty)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// apply one request to the sorted list and return what the block should answer
	function automatic spq_result_t apply_request(logic req, spq_pkg::data_t v);
		spq_result_t r;
		int          pos;
		r.out_value = '0;
		r.status    = spq_pkg::ST_OK;
		if (req == spq_pkg::REQ_ENQ) begin
			if (sorted_entries.size() >= spq_pkg::CAPACITY) begin
				// full: value dropped, contents unchanged
				r.status = spq_pkg::ST_FULL;
			end else begin
				// new value goes behind every entry that is greater or equal
				pos = 0;
				while (pos < sorted_entries.size() && !(sorted_entries[pos] < v))
					pos++;
				sorted_entries.insert(pos, v);
			end
		end else begin
			if (sorted_entries.size() == 0) begin
				// empty: returns all ones with the empty status
				r.out_value = -1;
				r.status    = spq_pkg::ST_EMPTY;
			end else begin
				r.out_value = sorted_entries.pop_front();
			end
		end
		r.entry_count = spq_pkg::ECOUNT_W'(sorted_entries.size());
		r.is_empty    = (sorted_entries.size() == 0);
		return r;
	endfunction

	task automatic report_mismatch(string field, logic [spq_pkg::VALUE_W-1:0] got,
			logic [spq_pkg::VALUE_W-1:0] want);
		mismatch_count++;
		if (mismatch_count <= PRINT_LIMIT)
			$display("mismatch on result %0d, %s: got %h, want %h",
				result_count, field, got, want);
	endtask

	// a mix of extremes, small values that tie often, and full-range values
	function automatic spq_pkg::data_t pick_value();
		case ($urandom_range(0, 9))
			0: return {1'b0, {(spq_pkg::DATA_WIDTH-1){1'b1}}};
			1: return {1'b1, {(spq_pkg::DATA_WIDTH-1){1'b0}}};
			2: return ($urandom_range(0, 1) != 0) ? spq_pkg::data_t'(0)
				: spq_pkg::data_t'(-1);
			3, 4, 5: return spq_pkg::data_t'($signed($urandom_range(0, 6)) - 3);
			default: return spq_pkg::data_t'($urandom());
		endcase
	endfunction

	// drive one transaction, hold it until accepted, then idle for the given gap
	task automatic send_request(logic req, spq_pkg::data_t v, bit fixed,
			spq_result_t res, int gap);
		start      <= 1'b1;
		req_type   <= req;
		value      <= v;
		row_fixed  <= fixed;
		row_expect <= res;
		do @(posedge clk); while (busy);
		// with no gap start stays high for the next transaction
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// results are checked before the transaction of this edge is recorded,
	// so the oldest owed result is always the one that comes out now
	always @(posedge clk) begin : result_check
		spq_result_t want;
		spq_result_t pred;
		if (arst_n) begin
			if (done) begin
				result_count++;
				if (owed_results.size() == 0) begin
					report_mismatch("result with no transaction waiting", out_value, '0);
				end else begin
					want = owed_results.pop_front();
					if (out_value !== want.out_value)
						report_mismatch("out_value", out_value, want.out_value);
					if (status !== want.status)
						report_mismatch("status", spq_pkg::VALUE_W'(status),
							spq_pkg::VALUE_W'(want.status));
					if (entry_count !== want.entry_count)
						report_mismatch("entry_count", spq_pkg::VALUE_W'(entry_count),
							spq_pkg::VALUE_W'(want.entry_count));
					if (is_empty !== want.is_empty)
						report_mismatch("is_empty", spq_pkg::VALUE_W'(is_empty),
							spq_pkg::VALUE_W'(want.is_empty));
				end
			end
			if (start && !busy) begin
				// the list is always updated, a typed row only replaces the answer
				pred = apply_request(req_type, value);
				owed_results.push_back(row_fixed ? row_expect : pred);
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin : stimulus
		spq_result_t none;
		int          sent;
		int          phase_len;
		int          enq_pct;
		bit          quiet;
		logic        req;
		int          gap;

		arst_n     = 1'b0;
		start      = 1'b0;
		req_type   = spq_pkg::REQ_ENQ;
		value      = '0;
		row_fixed  = 1'b0;
		row_expect = '0;
		none       = '0;
		mismatch_count = 0;
		result_count   = 0;
		cycle_count    = 0;

		dir_rows = '{
			// dequeue straight after reset
			'{spq_pkg::REQ_DEQ, spq_pkg::data_t'(0), 1, 1'b1,
				'{-1, spq_pkg::ST_EMPTY, 7'd0, 1'b1}},
			// extremes in, then out in order
			'{spq_pkg::REQ_ENQ, spq_pkg::data_t'(32'h7fffffff), 1, 1'b1,
				'{0, spq_pkg::ST_OK, 7'd1, 1'b0}},
			'{spq_pkg::REQ_ENQ, spq_pkg::data_t'(32'h80000000), 1, 1'b1,
				'{0, spq_pkg::ST_OK, 7'd2, 1'b0}},
			'{spq_pkg::REQ_ENQ, spq_pkg::data_t'(0), 1, 1'b1,
				'{0, spq_pkg::ST_OK, 7'd3, 1'b0}},
			'{spq_pkg::REQ_DEQ, spq_pkg::data_t'(32'hffffffff), 1, 1'b1,
				'{32'sh7fffffff, spq_pkg::ST_OK, 7'd2, 1'b0}},
			'{spq_pkg::REQ_DEQ, spq_pkg::data_t'(32'h12345678), 1, 1'b1,
				'{0, spq_pkg::ST_OK, 7'd1, 1'b0}},
			'{spq_pkg::REQ_DEQ, spq_pkg::data_t'(0), 1, 1'b1,
				'{32'sh80000000, spq_pkg::ST_OK, 7'd0, 1'b1}},
			'{spq_pkg::REQ_DEQ, spq_pkg::data_t'(32'h7fffffff), 1, 1'b1,
				'{-1, spq_pkg::ST_EMPTY, 7'd0, 1'b1}},
			// ties and mixed signs
			'{spq_pkg::REQ_ENQ, spq_pkg::data_t'(5), 1, 1'b0,
				'{0, spq_pkg::ST_OK, 7'd0, 1'b0}},
			'{spq_pkg::REQ_ENQ, spq_pkg::data_t'(5), 1, 1'b0,
				'{0, spq_pkg::ST_OK, 7'd0, 1'b0}},
			'{spq_pkg::REQ_ENQ, spq_pkg::data_t'(-7), 1, 1'b0,
				'{0, spq_pkg::ST_OK, 7'd0, 1'b0}},
			'{spq_pkg::REQ_ENQ, spq_pkg::data_t'(5), 1, 1'b0,
				'{0, spq_pkg::ST_OK, 7'd0, 1'b0}},
			'{spq_pkg::REQ_ENQ, spq_pkg::data_t'(9), 1, 1'b0,
				'{0, spq_pkg::ST_OK, 7'd0, 1'b0}},
			// drain one past empty
			'{spq_pkg::REQ_DEQ, spq_pkg::data_t'(0), 6, 1'b0,
				'{0, spq_pkg::ST_OK, 7'd0, 1'b0}},
			// fill to capacity, then enqueues are refused
			'{spq_pkg::REQ_ENQ, spq_pkg::data_t'(32'h55555555), spq_pkg::CAPACITY, 1'b0,
				'{0, spq_pkg::ST_OK, 7'd0, 1'b0}},
			'{spq_pkg::REQ_ENQ, spq_pkg::data_t'(32'haaaaaaaa), 1, 1'b1,
				'{0, spq_pkg::ST_FULL, spq_pkg::ECOUNT_W'(spq_pkg::CAPACITY), 1'b0}},
			'{spq_pkg::REQ_ENQ, spq_pkg::data_t'(32'h7fffffff), 1, 1'b1,
				'{0, spq_pkg::ST_FULL, spq_pkg::ECOUNT_W'(spq_pkg::CAPACITY), 1'b0}},
			'{spq_pkg::REQ_DEQ, spq_pkg::data_t'(0), 1, 1'b1,
				'{32'sh55555555, spq_pkg::ST_OK,
					spq_pkg::ECOUNT_W'(spq_pkg::CAPACITY - 1), 1'b0}},
			'{spq_pkg::REQ_ENQ, spq_pkg::data_t'(-1), 1, 1'b0,
				'{0, spq_pkg::ST_OK, 7'd0, 1'b0}},
			// drain from full down to empty
			'{spq_pkg::REQ_DEQ, spq_pkg::data_t'(32'hffffffff), spq_pkg::CAPACITY, 1'b0,
				'{0, spq_pkg::ST_OK, 7'd0, 1'b0}},
			'{spq_pkg::REQ_DEQ, spq_pkg::data_t'(0), 1, 1'b1,
				'{-1, spq_pkg::ST_EMPTY, 7'd0, 1'b1}}
		};

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		foreach (dir_rows[r]) begin
			for (int k = 0; k < dir_rows[r].reps; k++) begin
				gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, MAX_GAP);
				send_request(dir_rows[r].req, dir_rows[r].val, dir_rows[r].fixed,
					dir_rows[r].res, gap);
			end
		end

		// random phases: filling pushes the queue toward full, draining toward empty, mixed phases stay balanced
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			phase_len = $urandom_range(20, 150);
			case ($urandom_range(0, 2))
				0: enq_pct = 85;
				1: enq_pct = 15;
				default: enq_pct = 50;
			endcase
			quiet = ($urandom_range(0, 3) == 0);
			for (int k = 0; k < phase_len && sent < RANDOM_ITEMS; k++) begin
				req = ($urandom_range(0, 99) < enq_pct) ? spq_pkg::REQ_ENQ : spq_pkg::REQ_DEQ;
				gap = quiet ? 0 : $urandom_range(0, MAX_GAP);
				send_request(req, pick_value(), 1'b0, none, gap);
				sent++;
			end
		end

		start <= 1'b0;
		@(posedge clk);
		while (owed_results.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (owed_results.size() != 0)
			report_mismatch("results never delivered",
				spq_pkg::VALUE_W'(owed_results.size()), '0);

		if (mismatch_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

// File: sim.f
hw/rtl/spq_pkg.sv
hw/rtl/spq_cell.sv
hw/rtl/sorted_priority_queue.sv
tb/sv/sorted_priority_queue_tb.sv
